// ===== design/moesif_pkg.sv =====
// Package for the MOESIF snooping coherence controller.
// Holds the line state and command codes and the default table depth.
// Has no dependencies; the controller top level imports it.
package moesif_pkg;

	localparam int DefLineSlots = 1024;

	localparam int CmdW   = 3;
	localparam int SlotInW = 10;
	localparam int AddrW  = 32;
	localparam int NodeW  = 4;
	localparam int StateW = 4;

	typedef enum logic [StateW-1:0] {
		ST_I  = 4'd0,
		ST_S  = 4'd1,
		ST_E  = 4'd2,
		ST_O  = 4'd3,
		ST_M  = 4'd4,
		ST_F  = 4'd5,
		ST_IM = 4'd6,
		ST_IS = 4'd7,
		ST_SM = 4'd8,
		ST_OM = 4'd9,
		ST_FM = 4'd10
	} line_state_t;

	typedef enum logic [CmdW-1:0] {
		CMD_LOAD  = 3'd0,
		CMD_STORE = 3'd1,
		CMD_GETS  = 3'd2,
		CMD_GETM  = 3'd3,
		CMD_DATA  = 3'd4
	} cmd_t;

endpackage

// ===== design/moesif_coherence_controller_unit.sv =====
// MOESIF snooping coherence controller: line state table and transition logic.
// Each event is registered with its table read, then its result is registered at the output;
// one event per cycle while results are taken and no clearing pass runs. The state memory
// has one read and one write port, read at transfer and written as the event moves on,
// with forwarding of the last write to a back-to-back event. After reset a clearing pass writes I
// to every entry, during which no event is taken.
module moesif_coherence_controller_unit #(
	parameter int LINE_SLOTS = moesif_pkg::DefLineSlots
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [moesif_pkg::CmdW-1:0]    command,
	input  logic [moesif_pkg::SlotInW-1:0] line_slot,
	input  logic [moesif_pkg::AddrW-1:0]   address,
	input  logic [moesif_pkg::NodeW-1:0]   requester_id,
	input  logic                         shared_seen,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic                         issue_gets,
	output logic                         issue_getm,
	output logic                         data_to_processor,
	output logic                         data_to_bus,
	output logic [moesif_pkg::NodeW-1:0]   bus_destination,
	output logic [moesif_pkg::AddrW-1:0]   address_out,
	output logic                         assert_shared,
	output logic                         miss_event,
	output logic                         silent_upgrade,
	output logic                         protocol_error,
	output logic [moesif_pkg::StateW-1:0]  next_line_state
);
	import moesif_pkg::*;

	localparam int SlotW = (LINE_SLOTS > 1) ? $clog2(LINE_SLOTS) : 1;
	localparam int Recip = (1 << 20) / LINE_SLOTS;

	logic [StateW-1:0] mem [LINE_SLOTS];

	logic              clear_q;
	logic [SlotW-1:0]  clr_idx_q;
	logic [SlotW-1:0]  slot_in;

	logic              valid_s1;
	logic [CmdW-1:0]   cmd_s1;
	logic [SlotW-1:0]  slot_s1;
	logic [AddrW-1:0]  addr_s1;
	logic [NodeW-1:0]  req_s1;
	logic              shared_s1;
	logic [StateW-1:0] rd_s1;

	logic              fwd_valid_q;
	logic [SlotW-1:0]  fwd_slot_q;
	logic [StateW-1:0] fwd_state_q;

	logic              accept;
	logic              adv;
	logic              mem_we;
	logic [SlotW-1:0]  mem_waddr;
	logic [StateW-1:0] mem_wdata;

	logic [StateW-1:0] raw_st;
	line_state_t       cur;
	line_state_t       nx;
	logic gets, getm, dproc, dbus, ashr, miss, silent, err;

	// Reduce the slot number modulo the table depth.
	generate
		if (LINE_SLOTS >= (1 << SlotInW)) begin : g_slot_direct
			assign slot_in = SlotW'(line_slot);
		end else begin : g_slot_mod
			logic [30:0] prod;
			logic [SlotInW-1:0] quo;
			logic [19:0] qm;
			logic [SlotInW-1:0] rem;
			logic [SlotInW-1:0] rem_fix;
			assign prod = 31'(line_slot) * 31'(Recip);
			assign quo = prod[29:20];
			assign qm = 20'(quo) * 20'(LINE_SLOTS);
			assign rem = SlotInW'(20'(line_slot) - qm);
			assign rem_fix = (rem >= SlotInW'(LINE_SLOTS)) ? rem - SlotInW'(LINE_SLOTS) : rem;
			assign slot_in = SlotW'(rem_fix);
		end
	endgenerate

	assign adv      = valid_s1 && (!out_valid || out_ready);
	assign in_ready = !clear_q && (!valid_s1 || adv);
	assign accept   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_q   <= 1'b1;
			clr_idx_q <= '0;
		end else if (clear_q) begin
			if (clr_idx_q == SlotW'(LINE_SLOTS - 1)) begin
				clear_q <= 1'b0;
			end
			clr_idx_q <= clr_idx_q + 1'b1;
		end
	end

	assign mem_we    = clear_q || adv;
	assign mem_waddr = clear_q ? clr_idx_q : slot_s1;
	assign mem_wdata = clear_q ? StateW'(ST_I) : StateW'(nx);

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (accept) begin
			rd_s1 <= mem[slot_in];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1    <= command;
			slot_s1   <= slot_in;
			addr_s1   <= address;
			req_s1    <= requester_id;
			shared_s1 <= shared_seen;
		end
	end

	// The last write-back overrides a read of the same entry that it overtook.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_valid_q <= 1'b0;
		end else if (adv) begin
			fwd_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			fwd_slot_q  <= slot_s1;
			fwd_state_q <= StateW'(nx);
		end
	end

	assign raw_st = (fwd_valid_q && fwd_slot_q == slot_s1) ? fwd_state_q : rd_s1;
	assign cur = (raw_st > StateW'(ST_FM)) ? ST_I : line_state_t'(raw_st);

	always_comb begin
		nx     = cur;
		gets   = 1'b0;
		getm   = 1'b0;
		dproc  = 1'b0;
		dbus   = 1'b0;
		ashr   = 1'b0;
		miss   = 1'b0;
		silent = 1'b0;
		err    = 1'b0;
		case (cmd_s1) inside
			CMD_LOAD, CMD_STORE: begin
				case (cur) inside
					ST_I: begin
						miss = 1'b1;
						if (cmd_s1 == CMD_STORE) begin
							getm = 1'b1;
							nx   = ST_IM;
						end else begin
							gets = 1'b1;
							nx   = ST_IS;
						end
					end
					ST_S, ST_O, ST_F: begin
						if (cmd_s1 == CMD_STORE) begin
							getm = 1'b1;
							nx   = (cur == ST_S) ? ST_SM : (cur == ST_O) ? ST_OM : ST_FM;
						end else begin
							dproc = 1'b1;
						end
					end
					ST_E: begin
						dproc = 1'b1;
						if (cmd_s1 == CMD_STORE) begin
							nx     = ST_M;
							silent = 1'b1;
						end
					end
					ST_M: dproc = 1'b1;
					default: err = 1'b1;
				endcase
			end
			CMD_GETS: begin
				case (cur) inside
					ST_S, ST_SM: ashr = 1'b1;
					ST_E: begin
						ashr = 1'b1;
						dbus = 1'b1;
						nx   = ST_F;
					end
					ST_M: begin
						ashr = 1'b1;
						dbus = 1'b1;
						nx   = ST_O;
					end
					ST_O, ST_F, ST_OM, ST_FM: begin
						ashr = 1'b1;
						dbus = 1'b1;
					end
					default: ;
				endcase
			end
			CMD_GETM: begin
				case (cur) inside
					ST_S: nx = ST_I;
					ST_SM: begin
						nx   = ST_IM;
						miss = 1'b1;
					end
					ST_E, ST_M, ST_O, ST_F: begin
						dbus = 1'b1;
						nx   = ST_I;
					end
					ST_OM, ST_FM: begin
						dbus = 1'b1;
						nx   = ST_IM;
						miss = 1'b1;
					end
					default: ;
				endcase
			end
			CMD_DATA: begin
				case (cur) inside
					ST_IM, ST_SM, ST_OM, ST_FM: begin
						dproc = 1'b1;
						nx    = ST_M;
					end
					ST_IS: begin
						dproc = 1'b1;
						nx    = shared_s1 ? ST_S : ST_E;
					end
					default: ;
				endcase
			end
			default: err = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			issue_gets        <= gets;
			issue_getm        <= getm;
			data_to_processor <= dproc;
			data_to_bus       <= dbus;
			bus_destination   <= dbus ? req_s1 : '0;
			address_out       <= (gets || getm || dproc || dbus) ? addr_s1 : '0;
			assert_shared     <= ashr;
			miss_event        <= miss;
			silent_upgrade    <= silent;
			protocol_error    <= err;
			next_line_state   <= StateW'(nx);
		end
	end

	a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		clear_q |-> !accept)
		else $error("event transfer during the clearing pass");

	a_result_from_stage: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(valid_s1))
		else $error("result appeared without an event in flight");

	a_error_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && protocol_error |->
			!(issue_gets || issue_getm || data_to_processor || data_to_bus || miss_event))
		else $error("protocol error result carries bus or processor activity");

	a_silent_to_m: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && silent_upgrade |-> next_line_state == StateW'(ST_M))
		else $error("silent upgrade did not end in M");

	a_dest_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !data_to_bus |-> bus_destination == '0)
		else $error("bus destination set without bus data");

endmodule

// ===== dv/moesif_checker.sv =====
// Checker for the MOESIF coherence controller: watches both channels, predicts
// each result from its own copy of the line state table and compares field by field.
// Depends on moesif_pkg for the state and command codes.
`timescale 1ns / 1ps

module moesif_checker #(
	parameter int LINE_SLOTS = moesif_pkg::DefLineSlots
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	input  logic                           in_ready,
	input  logic [moesif_pkg::CmdW-1:0]    command,
	input  logic [moesif_pkg::SlotInW-1:0] line_slot,
	input  logic [moesif_pkg::AddrW-1:0]   address,
	input  logic [moesif_pkg::NodeW-1:0]   requester_id,
	input  logic                           shared_seen,
	input  logic                           out_valid,
	input  logic                           out_ready,
	input  logic                           issue_gets,
	input  logic                           issue_getm,
	input  logic                           data_to_processor,
	input  logic                           data_to_bus,
	input  logic [moesif_pkg::NodeW-1:0]   bus_destination,
	input  logic [moesif_pkg::AddrW-1:0]   address_out,
	input  logic                           assert_shared,
	input  logic                           miss_event,
	input  logic                           silent_upgrade,
	input  logic                           protocol_error,
	input  logic [moesif_pkg::StateW-1:0]  next_line_state,
	output int                             mismatches,
	output int                             pending_results
);
	import moesif_pkg::*;

	typedef struct {
		logic             gets;
		logic             getm;
		logic             to_proc;
		logic             to_bus;
		logic [NodeW-1:0] dest;
		logic [AddrW-1:0] addr;
		logic             shared;
		logic             miss;
		logic             silent;
		logic             err;
		line_state_t      next_state;
	} coh_response_t;

	line_state_t   line_states [LINE_SLOTS];
	coh_response_t response_q [$];
	coh_response_t predicted;
	coh_response_t oldest;
	int            slot_idx;

	function automatic coh_response_t predict_response(
		input logic [CmdW-1:0]  cmd,
		input line_state_t      cur,
		input logic [AddrW-1:0] addr,
		input logic [NodeW-1:0] req,
		input logic             shared
	);
		coh_response_t r;
		r = '{default: '0, next_state: cur};
		case (cmd) inside
			CMD_LOAD, CMD_STORE: begin
				case (cur) inside
					ST_I: begin
						r.miss = 1'b1;
						if (cmd == CMD_STORE) begin
							r.getm = 1'b1;
							r.next_state = ST_IM;
						end else begin
							r.gets = 1'b1;
							r.next_state = ST_IS;
						end
					end
					ST_S, ST_O, ST_F: begin
						if (cmd == CMD_STORE) begin
							r.getm = 1'b1;
							r.next_state = (cur == ST_S) ? ST_SM : (cur == ST_O) ? ST_OM : ST_FM;
						end else begin
							r.to_proc = 1'b1;
						end
					end
					ST_E: begin
						r.to_proc = 1'b1;
						if (cmd == CMD_STORE) begin
							r.next_state = ST_M;
							r.silent = 1'b1;
						end
					end
					ST_M: r.to_proc = 1'b1;
					default: r.err = 1'b1;
				endcase
			end
			CMD_GETS: begin
				case (cur) inside
					ST_S, ST_SM: r.shared = 1'b1;
					ST_E, ST_M, ST_O, ST_F, ST_OM, ST_FM: begin
						r.shared = 1'b1;
						r.to_bus = 1'b1;
						if (cur == ST_E) r.next_state = ST_F;
						if (cur == ST_M) r.next_state = ST_O;
					end
					default: ;
				endcase
			end
			CMD_GETM: begin
				case (cur) inside
					ST_S: r.next_state = ST_I;
					ST_SM: begin
						r.next_state = ST_IM;
						r.miss = 1'b1;
					end
					ST_E, ST_M, ST_O, ST_F: begin
						r.to_bus = 1'b1;
						r.next_state = ST_I;
					end
					ST_OM, ST_FM: begin
						r.to_bus = 1'b1;
						r.next_state = ST_IM;
						r.miss = 1'b1;
					end
					default: ;
				endcase
			end
			CMD_DATA: begin
				case (cur) inside
					ST_IM, ST_SM, ST_OM, ST_FM: begin
						r.to_proc = 1'b1;
						r.next_state = ST_M;
					end
					ST_IS: begin
						r.to_proc = 1'b1;
						r.next_state = shared ? ST_S : ST_E;
					end
					default: ;
				endcase
			end
			default: r.err = 1'b1;
		endcase
		r.dest = r.to_bus ? req : '0;
		r.addr = (r.gets || r.getm || r.to_proc || r.to_bus) ? addr : '0;
		return r;
	endfunction

	task automatic check_field(input string name, input logic [AddrW-1:0] want,
			input logic [AddrW-1:0] got);
		if (want !== got) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (line_states[i]) line_states[i] = ST_I;
			response_q.delete();
			mismatches = 0;
			pending_results = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (response_q.size() == 0) begin
					$error("result transfer with no event outstanding");
					mismatches++;
				end else begin
					oldest = response_q.pop_front();
					check_field("issue_gets", oldest.gets, issue_gets);
					check_field("issue_getm", oldest.getm, issue_getm);
					check_field("data_to_processor", oldest.to_proc, data_to_processor);
					check_field("data_to_bus", oldest.to_bus, data_to_bus);
					check_field("bus_destination", oldest.dest, bus_destination);
					check_field("address_out", oldest.addr, address_out);
					check_field("assert_shared", oldest.shared, assert_shared);
					check_field("miss_event", oldest.miss, miss_event);
					check_field("silent_upgrade", oldest.silent, silent_upgrade);
					check_field("protocol_error", oldest.err, protocol_error);
					check_field("next_line_state", oldest.next_state, next_line_state);
				end
			end
			if (in_valid && in_ready) begin
				slot_idx = int'(line_slot) % LINE_SLOTS;
				predicted = predict_response(command, line_states[slot_idx], address,
					requester_id, shared_seen);
				line_states[slot_idx] = predicted.next_state;
				response_q.push_back(predicted);
			end
			pending_results = response_q.size();
		end
	end

endmodule

// ===== dv/tb_top.sv =====
// Top of the coherence controller testbench: clock, reset, event stimulus and verdict.
// Instantiates moesif_coherence_controller_unit and moesif_checker; uses moesif_pkg.
`timescale 1ns / 1ps

module tb_top;
	import moesif_pkg::*;

	localparam int RandomEvents = 1550;
	localparam int CycleLimit = 200000;
	localparam logic [CmdW-1:0] CmdReserved = 3'b111;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	logic [CmdW-1:0]     command = '0;
	logic [SlotInW-1:0]  line_slot = '0;
	logic [AddrW-1:0]    address = '0;
	logic [NodeW-1:0]    requester_id = '0;
	logic                shared_seen = 1'b0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic                issue_gets;
	logic                issue_getm;
	logic                data_to_processor;
	logic                data_to_bus;
	logic [NodeW-1:0]    bus_destination;
	logic [AddrW-1:0]    address_out;
	logic                assert_shared;
	logic                miss_event;
	logic                silent_upgrade;
	logic                protocol_error;
	logic [StateW-1:0]   next_line_state;

	int                  mismatches;
	int                  pending_results;
	int                  events_sent = 0;
	int                  cycles = 0;
	int                  next_drain = 400;
	logic                steady = 1'b0;
	logic [SlotInW-1:0]  hot_slots [12];

	moesif_coherence_controller_unit dut (.*);

	moesif_checker chk (.*);

	initial begin
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CycleLimit) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	always @(negedge clk) begin
		out_ready <= steady || ($urandom_range(99) >= 29);
	end

	task automatic send_event(input logic [CmdW-1:0] cmd, input logic [SlotInW-1:0] slot,
			input logic [AddrW-1:0] addr, input logic [NodeW-1:0] req, input logic shared);
		while (!steady && $urandom_range(99) < 29) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		command <= cmd;
		line_slot <= slot;
		address <= addr;
		requester_id <= req;
		shared_seen <= shared;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		@(negedge clk);
		events_sent++;
	endtask

	function automatic logic [SlotInW-1:0] pick_slot();
		if ($urandom_range(99) < 70) return hot_slots[$urandom_range(11)];
		return SlotInW'($urandom());
	endfunction

	task automatic wait_for_results();
		while (pending_results != 0) @(negedge clk);
	endtask

	// A load or store, up to two snoops on the same slot, the data fill, then up to three loads or stores on the line.
	task automatic line_transaction();
		logic [SlotInW-1:0] slot;
		logic [AddrW-1:0]   addr;
		slot = pick_slot();
		addr = $urandom();
		send_event($urandom_range(1) ? CMD_STORE : CMD_LOAD, slot, addr, NodeW'($urandom()),
			1'($urandom()));
		repeat ($urandom_range(2))
			send_event($urandom_range(1) ? CMD_GETM : CMD_GETS, slot, $urandom(),
				NodeW'($urandom()), 1'($urandom()));
		send_event(CMD_DATA, slot, addr, NodeW'($urandom()), 1'($urandom()));
		repeat ($urandom_range(3))
			send_event($urandom_range(1) ? CMD_STORE : CMD_LOAD, slot, addr,
				NodeW'($urandom()), 1'($urandom()));
	endtask

	initial begin
		foreach (hot_slots[i]) hot_slots[i] = SlotInW'($urandom());
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Walk line 0 through IS, E, F, FM, M, O, OM, IM, M and back to I, then exercise other slots and a reserved command.
		send_event(CMD_LOAD, '0, '0, '0, 1'b0);
		send_event(CMD_DATA, '0, '0, '0, 1'b0);
		send_event(CMD_GETS, '0, $urandom(), '1, 1'b0);
		send_event(CMD_STORE, '0, $urandom(), '0, 1'b0);
		send_event(CMD_LOAD, '0, $urandom(), '0, 1'b0);
		send_event(CMD_GETS, '0, $urandom(), 4'h5, 1'b1);
		send_event(CMD_DATA, '0, $urandom(), '0, 1'b1);
		send_event(CMD_GETS, '0, $urandom(), 4'ha, 1'b0);
		send_event(CMD_STORE, '0, $urandom(), '0, 1'b0);
		send_event(CMD_GETM, '0, $urandom(), '1, 1'b0);
		send_event(CMD_DATA, '0, $urandom(), '0, 1'b0);
		send_event(CMD_GETM, '0, $urandom(), 4'h3, 1'b0);
		send_event(CMD_STORE, '1, '1, '1, 1'b1);
		send_event(CMD_GETS, '1, '1, '1, 1'b1);
		send_event(CMD_DATA, '1, '1, '1, 1'b1);
		send_event(CMD_LOAD, 10'd5, $urandom(), '0, 1'b0);
		send_event(CMD_DATA, 10'd5, $urandom(), '0, 1'b0);
		send_event(CMD_STORE, 10'd5, $urandom(), '0, 1'b0);
		send_event(CMD_LOAD, 10'd7, $urandom(), '0, 1'b1);
		send_event(CMD_DATA, 10'd7, $urandom(), '0, 1'b1);
		send_event(CMD_STORE, 10'd7, $urandom(), '0, 1'b0);
		send_event(CMD_GETS, 10'd7, $urandom(), 4'h9, 1'b0);
		send_event(CMD_GETM, 10'd7, $urandom(), 4'h6, 1'b0);
		send_event(CmdReserved, 10'd7, $urandom(), '1, 1'b1);
		send_event(CMD_DATA, '1, '1, '1, 1'b0);
		in_valid <= 1'b0;
		@(negedge clk);
		wait_for_results();

		while (events_sent < RandomEvents + 25) begin
			steady = (events_sent >= 700 && events_sent < 1000);
			if ($urandom_range(99) < 75) begin
				line_transaction();
			end else begin
				send_event(CmdW'($urandom()), pick_slot(), $urandom(), NodeW'($urandom()),
					1'($urandom()));
			end
			if (events_sent >= next_drain) begin
				in_valid <= 1'b0;
				@(negedge clk);
				wait_for_results();
				next_drain += 400;
			end
		end
		steady = 1'b0;
		in_valid <= 1'b0;

		wait_for_results();
		repeat (8) @(negedge clk);
		if (mismatches == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
